### design/cal_pkg.sv
// Shared constants, codes and result type for the compacting array list.
package cal_pkg;

    localparam int CAL_CAPACITY    = 8;
    localparam int CAL_MAX_RESULTS = 8;

    // operation codes
    localparam logic [1:0] OP_LIST   = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    typedef struct packed {
        logic [1:0] status;
        logic [2:0] index;
        logic [7:0] value_res;
        logic [3:0] count;
        logic       last;
    } t_res;

endpackage

### design/cal_if.sv
// Valid/ready channel interfaces for the request and result items.
interface cal_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [7:0] value;
    logic [3:0] position;

    modport source (output valid, output operation, output value, output position,
                    input ready);
    modport sink   (input valid, input operation, input value, input position,
                    output ready);
endinterface

interface cal_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [2:0] index;
    logic [7:0] value_res;
    logic [3:0] count;
    logic       last;

    modport source (output valid, output status, output index, output value_res,
                    output count, output last, input ready);
    modport sink   (input valid, input status, input index, input value_res,
                    input count, input last, output ready);
endinterface

### design/cal_ram.sv
// Entry store: one write port, one read port with registered read data.
module cal_ram #(
    parameter int DEPTH = 8,
    parameter int AW    = 3
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/cal_ctrl.sv
// Sequencer: decodes operations, walks the store for list and remove, owns the result register.
module cal_ctrl
    import cal_pkg::*;
#(
    parameter int CAPACITY = CAL_CAPACITY,
    parameter int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    cal_in_if.sink        i_in,
    cal_out_if.source     o_out,
    output logic          o_we,
    output logic [AW-1:0] o_waddr,
    output logic [7:0]    o_wdata,
    output logic          o_re,
    output logic [AW-1:0] o_raddr,
    input  logic [7:0]    i_rdata
);

    localparam int CW = $clog2(CAPACITY + 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_LIST  = 2'd1;
    localparam logic [1:0] S_SHIFT = 2'd2;
    localparam logic [1:0] S_PUSH  = 2'd3;

    logic [1:0]    r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_ptr,   n_ptr;
    logic [CW-1:0] r_lim,   n_lim;
    t_res          r_res,   n_res;
    t_res          r_odata, n_odata;
    logic          r_ovalid, n_ovalid;

    logic          slot_free;
    logic [CW-1:0] ptr_inc;
    logic [CW:0]   ptr_p2;
    logic [CW-1:0] pos_inc;

    assign slot_free = !r_ovalid || o_out.ready;
    assign ptr_inc   = r_ptr + CW'(1);
    assign ptr_p2    = (CW+1)'(r_ptr) + (CW+1)'(2);
    assign pos_inc   = CW'(i_in.position) + CW'(1);

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_ptr    = r_ptr;
        n_lim    = r_lim;
        n_res    = r_res;
        n_odata  = r_odata;
        n_ovalid = r_ovalid;
        o_we     = 1'b0;
        o_waddr  = r_count[AW-1:0];
        o_wdata  = i_in.value;
        o_re     = 1'b0;
        o_raddr  = r_ptr[AW-1:0];

        if (r_ovalid && o_out.ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_res   = '{status: ST_OK, index: '0, value_res: '0,
                                count: 4'(r_count), last: 1'b1};
                    n_state = S_PUSH;
                    case (i_in.operation)
                        OP_LIST: begin
                            if (r_count != '0) begin
                                n_ptr   = '0;
                                n_lim   = (32'(r_count) > CAL_MAX_RESULTS) ?
                                          CW'(CAL_MAX_RESULTS) : r_count;
                                o_re    = 1'b1;
                                o_raddr = '0;
                                n_state = S_LIST;
                            end
                        end
                        OP_APPEND: begin
                            if (32'(r_count) >= CAPACITY) begin
                                n_res.status = ST_FULL;
                            end else begin
                                o_we        = 1'b1;
                                n_count     = r_count + CW'(1);
                                n_res.count = 4'(r_count + CW'(1));
                            end
                        end
                        OP_REMOVE: begin
                            if (r_count == '0) begin
                                n_res.status = ST_EMPTY;
                            end else if (32'(i_in.position) >= 32'(r_count)) begin
                                n_res.status = ST_RANGE;
                            end else if (32'(i_in.position) + 1 < 32'(r_count)) begin
                                // later entries exist: move them down one a cycle
                                n_ptr   = CW'(i_in.position);
                                o_re    = 1'b1;
                                o_raddr = pos_inc[AW-1:0];
                                n_state = S_SHIFT;
                            end else begin
                                n_count     = r_count - CW'(1);
                                n_res.count = 4'(r_count - CW'(1));
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_LIST: begin
                if (slot_free) begin
                    n_ovalid = 1'b1;
                    n_odata  = '{status: ST_OK, index: 3'(r_ptr), value_res: i_rdata,
                                 count: 4'(r_count), last: (ptr_inc == r_lim)};
                    n_ptr    = ptr_inc;
                    if (ptr_inc == r_lim) begin
                        n_state = S_IDLE;
                    end else begin
                        o_re    = 1'b1;
                        o_raddr = ptr_inc[AW-1:0];
                    end
                end
            end
            S_SHIFT: begin
                o_we    = 1'b1;
                o_waddr = r_ptr[AW-1:0];
                o_wdata = i_rdata;
                n_ptr   = ptr_inc;
                if (ptr_p2 < (CW+1)'(r_count)) begin
                    o_re    = 1'b1;
                    o_raddr = ptr_p2[AW-1:0];
                end else begin
                    n_count = r_count - CW'(1);
                    n_res   = '{status: ST_OK, index: '0, value_res: '0,
                                count: 4'(r_count - CW'(1)), last: 1'b1};
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                if (slot_free) begin
                    n_ovalid = 1'b1;
                    n_odata  = r_res;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr   <= n_ptr;
        r_lim   <= n_lim;
        r_res   <= n_res;
        r_odata <= n_odata;
    end

    assign i_in.ready      = (r_state == S_IDLE);
    assign o_out.valid     = r_ovalid;
    assign o_out.status    = r_odata.status;
    assign o_out.index     = r_odata.index;
    assign o_out.value_res = r_odata.value_res;
    assign o_out.count     = r_odata.count;
    assign o_out.last      = r_odata.last;

endmodule

### design/compacting_array_list_top.sv
// Top level of the compacting array list: sequencer, entry store and checks.
// The list holds up to CAPACITY bytes in a single-port-read, single-port-write
// store. Each request item is append, remove or list, and yields one result
// item (list yields one per entry, at most eight, the final one marked last;
// an empty list gives one result with no entry). The block takes one request
// at a time and is not ready until that request's results are all loaded
// into the output register. Work follows the one read port of the store:
// a remove at position p moves each entry above p down one place, one entry
// moved down per cycle; a list reads its entries out in order, waiting on
// the sink whenever the output register is still full.
// A result may sit in the output register while the next request is accepted.
// Entries need no clearing after reset: only positions below the count are
// ever read, and those have all been written.
module compacting_array_list_top
    import cal_pkg::*;
#(
    parameter int CAPACITY = CAL_CAPACITY
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cal_in_if.sink    i_in,
    cal_out_if.source o_out
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    // store access from the sequencer
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;

    cal_ctrl #(
        .CAPACITY (CAPACITY),
        .AW       (AW)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_out   (o_out),
        .o_we    (ram_we),
        .o_waddr (ram_waddr),
        .o_wdata (ram_wdata),
        .o_re    (ram_re),
        .o_raddr (ram_raddr),
        .i_rdata (ram_rdata)
    );

    cal_ram #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // a request keeps the block busy in the cycle after it is accepted
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("request accepted while previous one still in flight");

    // error results never come mid-list
    a_error_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status != ST_OK) |-> o_out.last)
        else $error("error result not marked last");

    // only list entries carry a nonzero index, and they are always ok
    a_index_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.index != 3'd0) |-> (o_out.status == ST_OK && !o_out.index[2]
            || o_out.status == ST_OK))
        else $error("entry index on a non-ok result");

    // reported count never exceeds capacity (checked only when capacity is at most 15)
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (CAPACITY > 15 || 32'(o_out.count) <= CAPACITY))
        else $error("count beyond capacity");

endmodule

### bench/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the compacting array list: directed table, then random phases.
module tb_top;
    import cal_pkg::*;

    // selector value the block ignores; it has no name in the package
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int N_DIRECTED       = 23;
    localparam int N_PHASES         = 4;
    localparam int RANDOM_PER_PHASE = 90;
    localparam int HOLD_AT_ITEM     = 25;
    localparam int HOLD_CYCLES      = 80;
    localparam int SETTLE_CYCLES    = 24;
    localparam int MAX_PRINTS       = 60;
    localparam int TIMEOUT_NS       = 3_000_000;

    // One row of the directed table. When typed is set, the single result is
    // known up front: status and count as given, index 0, value 0, last 1.
    typedef struct packed {
        logic [1:0] op;
        logic [7:0] val;
        logic [3:0] pos;
        logic       typed;
        logic [1:0] st;
        logic [3:0] cnt;
    } t_cmd_row;

    logic i_clk;
    logic i_rst_n;

    cal_in_if  req_if ();
    cal_out_if res_if ();

    compacting_array_list_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_if),
        .o_out   (res_if)
    );

    // shadow copy of the list, updated when a request item is accepted
    logic [7:0] shadow_bytes [CAL_CAPACITY];
    logic [3:0] shadow_count;

    t_res expected_res_q [$];

    int error_count    = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_requests  = 0;
    int hold_served    = 0;
    int hold_left      = 0;

    // Walk the list from empty through full and partly back down, hitting each error code.
    t_cmd_row directed_rows [N_DIRECTED] = '{
        '{OP_LIST,   8'h00, 4'd0,  1'b1, ST_OK,    4'd0},  // list on empty
        '{OP_REMOVE, 8'h00, 4'd0,  1'b1, ST_EMPTY, 4'd0},  // remove on empty
        '{OP_REMOVE, 8'h00, 4'd15, 1'b1, ST_EMPTY, 4'd0},  // empty wins over range
        '{OP_UNUSED, 8'h00, 4'd0,  1'b1, ST_OK,    4'd0},
        '{OP_APPEND, 8'h00, 4'd0,  1'b1, ST_OK,    4'd1},
        '{OP_APPEND, 8'hFF, 4'd15, 1'b1, ST_OK,    4'd2},
        '{OP_APPEND, 8'h55, 4'd0,  1'b1, ST_OK,    4'd3},
        '{OP_APPEND, 8'hAA, 4'd0,  1'b1, ST_OK,    4'd4},
        '{OP_APPEND, 8'h01, 4'd0,  1'b1, ST_OK,    4'd5},
        '{OP_APPEND, 8'h80, 4'd0,  1'b1, ST_OK,    4'd6},
        '{OP_APPEND, 8'h7F, 4'd0,  1'b1, ST_OK,    4'd7},
        '{OP_APPEND, 8'hFE, 4'd0,  1'b1, ST_OK,    4'd8},
        '{OP_APPEND, 8'h33, 4'd0,  1'b1, ST_FULL,  4'd8},  // append when full
        '{OP_LIST,   8'h00, 4'd0,  1'b0, ST_OK,    4'd0},  // eight entries out
        '{OP_REMOVE, 8'h00, 4'd8,  1'b1, ST_RANGE, 4'd8},  // first bad position
        '{OP_REMOVE, 8'h00, 4'd15, 1'b1, ST_RANGE, 4'd8},
        '{OP_UNUSED, 8'hFF, 4'd15, 1'b1, ST_OK,    4'd8},
        '{OP_REMOVE, 8'h00, 4'd7,  1'b1, ST_OK,    4'd7},  // tail, nothing moves
        '{OP_REMOVE, 8'h00, 4'd0,  1'b1, ST_OK,    4'd6},  // head, longest shift
        '{OP_LIST,   8'h00, 4'd0,  1'b0, ST_OK,    4'd0},
        '{OP_REMOVE, 8'h00, 4'd2,  1'b1, ST_OK,    4'd5},
        '{OP_REMOVE, 8'h00, 4'd5,  1'b1, ST_RANGE, 4'd5},  // position equal to count
        '{OP_LIST,   8'h00, 4'd0,  1'b0, ST_OK,    4'd0}
    };

    // 12 ns clock
    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Apply one request to the shadow list and return the results it causes.
    function automatic void list_predict(input logic [1:0] op, input logic [7:0] val,
                                         input logic [3:0] pos, ref t_res outs[$]);
        t_res r;
        int   n;
        outs.delete();
        r.status    = ST_OK;
        r.index     = '0;
        r.value_res = '0;
        r.count     = shadow_count;
        r.last      = 1'b1;
        case (op)
            OP_LIST: begin
                n = (shadow_count > CAL_MAX_RESULTS) ? CAL_MAX_RESULTS : shadow_count;
                if (n == 0) begin
                    outs.push_back(r);
                end else begin
                    for (int i = 0; i < n; i++) begin
                        r.index     = 3'(i);
                        r.value_res = shadow_bytes[i];
                        r.last      = (i == n - 1);
                        outs.push_back(r);
                    end
                end
            end
            OP_APPEND: begin
                if (shadow_count >= CAL_CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    shadow_bytes[shadow_count] = val;
                    shadow_count = 4'(shadow_count + 4'd1);
                    r.count = shadow_count;
                end
                outs.push_back(r);
            end
            OP_REMOVE: begin
                if (shadow_count == 0) begin
                    r.status = ST_EMPTY;
                end else if (pos >= shadow_count) begin
                    r.status = ST_RANGE;
                end else begin
                    // close the gap: later entries move down one place
                    for (int i = pos; i + 1 < shadow_count; i++)
                        shadow_bytes[i] = shadow_bytes[i + 1];
                    shadow_count = 4'(shadow_count - 4'd1);
                    r.count = shadow_count;
                end
                outs.push_back(r);
            end
            default: outs.push_back(r);
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= MAX_PRINTS)
            $display("%0t ns: mismatch: %s", $time, what);
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    // Offer one request item, with an optional random gap first, and queue
    // its expected results once it is accepted.
    task automatic send_item(input logic [1:0] op, input logic [7:0] val,
                             input logic [3:0] pos, input logic typed,
                             input logic [1:0] want_st, input logic [3:0] want_cnt);
        t_res predicted [$];
        t_res typed_res;
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid     <= 1'b1;
        req_if.operation <= op;
        req_if.value     <= val;
        req_if.position  <= pos;
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
        list_predict(op, val, pos, predicted);
        if (typed) begin
            typed_res.status    = want_st;
            typed_res.index     = '0;
            typed_res.value_res = '0;
            typed_res.count     = want_cnt;
            typed_res.last      = 1'b1;
            expected_res_q.push_back(typed_res);
        end else begin
            foreach (predicted[k])
                expected_res_q.push_back(predicted[k]);
        end
    endtask

    // Result side: random stalls, plus a long hold-off when one is requested.
    always @(posedge i_clk) begin : result_sink
        if (hold_left > 0) begin
            hold_left--;
            res_if.ready <= 1'b0;
        end else if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES - 1;
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_res got;
        t_res want;
        if (i_rst_n && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
            got.status    = res_if.status;
            got.index     = res_if.index;
            got.value_res = res_if.value_res;
            got.count     = res_if.count;
            got.last      = res_if.last;
            if (expected_res_q.size() == 0) begin
                report_mismatch($sformatf("result with nothing pending: %p", got));
            end else begin
                want = expected_res_q.pop_front();
                check_field("status", got.status, want.status);
                check_field("index", got.index, want.index);
                check_field("value_res", got.value_res, want.value_res);
                check_field("count", got.count, want.count);
                check_field("last", got.last, want.last);
            end
        end
    end

    initial begin : stimulus
        t_cmd_row   row;
        logic [1:0] op;
        logic [7:0] val;
        logic [3:0] pos;
        logic       draining;
        int         pick;

        i_rst_n          = 1'b0;
        req_if.valid     = 1'b0;
        req_if.operation = OP_LIST;
        req_if.value     = '0;
        req_if.position  = '0;
        res_if.ready     = 1'b0;
        shadow_count     = '0;
        draining         = 1'b0;
        foreach (shadow_bytes[i])
            shadow_bytes[i] = '0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[r]) begin
            row = directed_rows[r];
            send_item(row.op, row.val, row.pos, row.typed, row.st, row.cnt);
        end

        // Phases: no idling, sender gaps, receiver stalls, light gaps on both.
        // Each phase starts with the list drained of pending results.
        for (int phase = 0; phase < N_PHASES; phase++) begin
            req_if.valid <= 1'b0;
            do @(posedge i_clk); while (expected_res_q.size() != 0);
            send_idle_pct  = (phase == 1) ? 47 : (phase == 3) ? 10 : 0;
            recv_stall_pct = (phase == 2) ? 47 : (phase == 3) ? 10 : 0;

            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                // long back-pressure while requests keep coming
                if (n == HOLD_AT_ITEM && (phase == 0 || phase == 2))
                    hold_requests++;

                // fill up, then drain; linger at the ends so full and empty
                // errors show up now and then
                if (shadow_count == CAL_CAPACITY && $urandom_range(3) == 0)
                    draining = 1'b1;
                if (shadow_count == 0 && $urandom_range(3) == 0)
                    draining = 1'b0;

                pick = $urandom_range(99);
                if (pick < 5)
                    op = OP_UNUSED;
                else if (pick < 20)
                    op = OP_LIST;
                else if (pick < 75)
                    op = draining ? OP_REMOVE : OP_APPEND;
                else
                    op = draining ? OP_APPEND : OP_REMOVE;

                val = 8'($urandom_range(255));
                // mostly a valid position, sometimes anything
                if (shadow_count != 0 && $urandom_range(9) < 8)
                    pos = 4'($urandom_range(32'(shadow_count) - 1));
                else
                    pos = 4'($urandom_range(15));

                send_item(op, val, pos, 1'b0, ST_OK, '0);
            end
        end

        req_if.valid <= 1'b0;
        do @(posedge i_clk); while (expected_res_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (error_count == 0)
            $display("PASS compacting_array_list_top");
        else
            $display("FAIL compacting_array_list_top");
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("FAIL compacting_array_list_top");
        $finish;
    end

endmodule

### files.f
design/cal_pkg.sv
design/cal_if.sv
design/cal_ram.sv
design/cal_ctrl.sv
design/compacting_array_list_top.sv
bench/tb_top.sv
